// ----- src/cmwc_pkg.sv -----
// Shared types, constants and lane step function for the combined MWC generator.
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_W     = 32;
  localparam int HALF_W     = 16;
  localparam int LANE_IDX_W = 3;
  localparam int PAIRS      = NUM_LANES / 2;

  typedef logic [LANE_IDX_W-1:0] lane_idx_t;
  typedef logic [LANE_W-1:0]     lane_word_t;

  typedef enum logic [1:0] {
    CMD_GENERATE = 2'd0,
    CMD_SEED     = 2'd1,
    CMD_SAVE     = 2'd2,
    CMD_RESTORE  = 2'd3
  } cmwc_cmd_t;

  typedef struct packed {
    logic      step;
    logic      seed_wr;
    logic      save;
    logic      restore;
    lane_idx_t lane;
  } cmwc_ctrl_t;

  localparam logic [HALF_W-1:0] LANE_MULT [NUM_LANES] = '{
    16'd18000, 16'd23163, 16'd28959, 16'd19074,
    16'd30903, 16'd19215, 16'd24948, 16'd21723
  };

  function automatic lane_word_t mwc_next(input lane_word_t v, input logic [HALF_W-1:0] m);
    lane_word_t prod;
    prod = {{HALF_W{1'b0}}, m} * {{HALF_W{1'b0}}, v[HALF_W-1:0]};
    return prod + {{HALF_W{1'b0}}, v[LANE_W-1:HALF_W]};
  endfunction

endpackage

`default_nettype wire

// ----- src/combined_mwc_random_word_generator_unit.sv -----
// Top level: input register, command decode, lane bank and output register.
// A generate word passes the input register, then the output register onto m_tdata.
// Throughput: one transaction per cycle unless m_tready stalls a generate.
// Seed, save and restore transactions produce no output transaction.
// Reset (rst, synchronous) clears all lanes, the snapshot and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module combined_mwc_random_word_generator_unit import cmwc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // lane[2:0], seed_value[34:3], zero[39:35]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // random_word[31:0]
);

  logic       in_valid;
  cmwc_cmd_t  in_cmd;
  lane_idx_t  in_lane;
  lane_word_t in_seed;
  logic       out_free;
  logic       advance;
  cmwc_ctrl_t ctrl;
  lane_word_t word;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && ((in_cmd != CMD_GENERATE) || out_free);
  assign s_tready = !in_valid || advance;

  always_comb begin
    ctrl.step    = advance && (in_cmd == CMD_GENERATE);
    ctrl.seed_wr = advance && (in_cmd == CMD_SEED);
    ctrl.save    = advance && (in_cmd == CMD_SAVE);
    ctrl.restore = advance && (in_cmd == CMD_RESTORE);
    ctrl.lane    = in_lane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= cmwc_cmd_t'(s_tuser);
      in_lane <= s_tdata[LANE_IDX_W-1:0];
      in_seed <= s_tdata[LANE_IDX_W+LANE_W-1:LANE_IDX_W];
    end
  end

  cmwc_lane_bank u_lane_bank (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .seed_value  (in_seed),
    .random_word (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      m_tdata <= word;
    end
  end

  a_word_from_generate: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl.step))
    else $error("output transaction without a generate command");

  a_blocked_item_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_cmd) && $stable(in_seed)))
    else $error("stalled input item lost or changed");

endmodule

`default_nettype wire

// ----- src/cmwc_lane_bank.sv -----
// Lane and snapshot registers with the per-lane step logic and word combine.
`timescale 1ns / 1ps
`default_nettype none

module cmwc_lane_bank import cmwc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmwc_ctrl_t ctrl,
  input  wire lane_word_t seed_value,
  output lane_word_t      random_word
);

  lane_word_t [NUM_LANES-1:0] lanes;
  lane_word_t [NUM_LANES-1:0] snapshot;
  lane_word_t [NUM_LANES-1:0] stepped;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      stepped[i] = mwc_next(lanes[i], LANE_MULT[i]);
    end
  end

  always_comb begin
    random_word = '0;
    for (int i = 0; i < PAIRS; i++) begin
      random_word = random_word ^ {stepped[i][HALF_W-1:0], {HALF_W{1'b0}}}
                    ^ {{HALF_W{1'b0}}, stepped[i+PAIRS][HALF_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes    <= '0;
      snapshot <= '0;
    end else begin
      if (ctrl.step) begin
        lanes <= stepped;
      end else if (ctrl.seed_wr) begin
        lanes[ctrl.lane] <= seed_value;
      end else if (ctrl.restore) begin
        lanes <= snapshot;
      end
      if (ctrl.save) begin
        snapshot <= lanes;
      end
    end
  end

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.step, ctrl.seed_wr, ctrl.save, ctrl.restore}))
    else $error("more than one lane command in a cycle");

  a_save_copies: assert property (@(posedge clk) disable iff (rst)
    ctrl.save |=> snapshot == $past(lanes))
    else $error("snapshot does not match saved lanes");

  a_restore_copies: assert property (@(posedge clk) disable iff (rst)
    ctrl.restore |=> lanes == $past(snapshot))
    else $error("lanes do not match restored snapshot");

endmodule

`default_nettype wire
